// ===== sv/ohtab_pkg.sv =====
package ohtab_pkg;

	localparam int DEF_BUCKET_COUNT = 20;
	localparam int DEF_POOL_ENTRIES = 64;
	localparam int DEF_KEY_CHARS    = 8;

	localparam logic [7:0] CHAR_FIRST = 8'h41;
	localparam logic [7:0] CHAR_LAST  = 8'h5A;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_LOOKUP = 1'b1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BADKEY   = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_FULL     = 2'd3
	} status_code_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HASH,
		S_MOD,
		S_DECIDE,
		S_INS,
		S_LINK,
		S_READ,
		S_CMP
	} state_t;

	typedef struct packed {
		logic         capture;
		logic         ins_write;
		logic         link_write;
		logic         ptr_head;
		logic         ptr_next;
		logic         load_out;
		status_code_t code;
	} oht_cmd_t;

	typedef struct packed {
		logic key_bad;
		logic is_lookup;
		logic full;
		logic head_used;
		logic hit;
		logic chain_end;
	} oht_sts_t;

endpackage

// ===== sv/ohtab_ctrl.sv =====
module ohtab_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  ohtab_pkg::oht_sts_t sts,
	output ohtab_pkg::oht_cmd_t cmd
);
	import ohtab_pkg::*;

	state_t       state_q, state_d;
	status_code_t res_q, res_d;
	logic         out_valid_q;
	logic         done_q, done_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_q       <= ST_OK;
			out_valid_q <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
			done_q  <= done_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// done_q: result code settled, waiting for room in the output register
	always_comb begin
		state_d = state_q;
		res_d   = res_q;
		done_d  = done_q;
		unique case (state_q)
			S_IDLE: begin
				if (done_q) begin
					if (!out_valid_q || out_ready) begin
						done_d = 1'b0;
					end
				end else if (in_valid) begin
					state_d = S_HASH;
				end
			end
			S_HASH:   state_d = S_MOD;
			S_MOD:    state_d = S_DECIDE;
			S_DECIDE: begin
				priority if (sts.key_bad) begin
					res_d   = ST_BADKEY;
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else if (!sts.is_lookup) begin
					if (sts.full) begin
						res_d   = ST_FULL;
						done_d  = 1'b1;
						state_d = S_IDLE;
					end else begin
						state_d = S_INS;
					end
				end else if (!sts.head_used) begin
					res_d   = ST_NOTFOUND;
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_READ;
				end
			end
			S_INS: begin
				res_d = ST_OK;
				if (sts.head_used) begin
					state_d = S_LINK;
				end else begin
					done_d  = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_LINK: begin
				done_d  = 1'b1;
				state_d = S_IDLE;
			end
			S_READ:   state_d = S_CMP;
			S_CMP: begin
				priority if (sts.hit) begin
					res_d   = ST_OK;
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else if (sts.chain_end) begin
					res_d   = ST_NOTFOUND;
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_READ;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready       = (state_q == S_IDLE) && !done_q;
		out_valid      = out_valid_q;
		cmd            = '0;
		cmd.code       = res_q;
		cmd.capture    = in_ready && in_valid;
		cmd.ins_write  = (state_q == S_INS);
		cmd.link_write = (state_q == S_LINK);
		cmd.ptr_head   = (state_q == S_DECIDE);
		cmd.ptr_next   = (state_q == S_CMP);
		cmd.load_out   = (state_q == S_IDLE) && done_q && (!out_valid_q || out_ready);
	end

endmodule

// ===== sv/ohtab_dpath.sv =====
module ohtab_dpath #(
	parameter int BUCKET_COUNT = ohtab_pkg::DEF_BUCKET_COUNT,
	parameter int POOL_ENTRIES = ohtab_pkg::DEF_POOL_ENTRIES,
	parameter int KEY_CHARS    = ohtab_pkg::DEF_KEY_CHARS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ohtab_pkg::oht_cmd_t cmd,
	output ohtab_pkg::oht_sts_t sts,
	input  logic                func,
	input  logic [63:0]         key_chars,
	input  logic [3:0]          key_length,
	input  logic [7:0]          opcode_value,
	input  logic [3:0]          format_value,
	output logic [1:0]          status,
	output logic [7:0]          found_opcode,
	output logic [3:0]          found_format,
	output logic [5:0]          bucket_index
);
	import ohtab_pkg::*;

	localparam int KEY_W = 8 * KEY_CHARS;
	localparam int IDX_W = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
	localparam int CNT_W = $clog2(POOL_ENTRIES + 1);
	localparam int BKT_W = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [3:0]       len;
		logic [7:0]       opc;
		logic [3:0]       fmt;
	} entry_t;

	// captured request
	logic             func_q;
	logic [KEY_W-1:0] key_q;
	logic [3:0]       len_q;
	logic [7:0]       opc_q;
	logic [3:0]       fmt_q;
	logic [KEY_W-1:0] key_m;
	logic [3:0]       len_c;

	// hash
	logic             bad_c, bad_q;
	logic [7:0]       sum_c, sum_q;
	logic [BKT_W-1:0] bkt_c, bkt_q;

	// table state
	logic [IDX_W-1:0] head_q [BUCKET_COUNT];
	logic [IDX_W-1:0] tail_q [BUCKET_COUNT];
	logic [BUCKET_COUNT-1:0] head_vld_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] new_idx;
	logic [IDX_W-1:0] link_addr_q, link_data_q;

	// pool memories
	entry_t           ent_mem [POOL_ENTRIES];
	logic [IDX_W:0]   nxt_mem [POOL_ENTRIES];
	entry_t           ent_rd_q;
	logic [IDX_W:0]   nxt_rd_q;
	logic [IDX_W-1:0] ptr_q;

	logic [1:0]       status_q;
	logic [7:0]       opc_out_q;
	logic [3:0]       fmt_out_q;
	logic [5:0]       bkt_out_q;

	always_comb begin
		len_c = (key_length > 4'(KEY_CHARS)) ? 4'(KEY_CHARS) : key_length;
		for (int i = 0; i < KEY_CHARS; i++) begin
			key_m[8*i +: 8] = (4'(i) < len_c) ? key_chars[8*i +: 8] : 8'h00;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= func;
			key_q  <= key_m;
			len_q  <= len_c;
			opc_q  <= opcode_value;
			fmt_q  <= format_value;
		end
	end

	always_comb begin
		logic [7:0] ch;
		bad_c = 1'b0;
		sum_c = '0;
		for (int i = 0; i < KEY_CHARS; i++) begin
			ch = key_q[8*i +: 8];
			if (4'(i) < len_q) begin
				if (ch < CHAR_FIRST || ch > CHAR_LAST) begin
					bad_c = 1'b1;
				end else begin
					sum_c = sum_c + (ch - CHAR_FIRST);
				end
			end
		end
	end

	// remainder by shifted subtraction of the bucket count
	always_comb begin
		logic [15:0] r;
		logic [15:0] d;
		r = {8'h00, sum_q};
		for (int k = 7; k >= 0; k--) begin
			d = 16'(BUCKET_COUNT) << k;
			if (r >= d) begin
				r = r - d;
			end
		end
		bkt_c = r[BKT_W-1:0];
	end

	always_ff @(posedge clk) begin
		bad_q <= bad_c;
		sum_q <= sum_c;
		bkt_q <= bkt_c;
	end

	assign new_idx = cnt_q[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q <= '0;
			cnt_q      <= '0;
		end else if (cmd.ins_write) begin
			head_vld_q[bkt_q] <= 1'b1;
			cnt_q             <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins_write) begin
			if (!head_vld_q[bkt_q]) begin
				head_q[bkt_q] <= new_idx;
			end
			tail_q[bkt_q] <= new_idx;
			link_addr_q   <= tail_q[bkt_q];
			link_data_q   <= new_idx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins_write) begin
			ent_mem[new_idx] <= '{key: key_q, len: len_q, opc: opc_q, fmt: fmt_q};
		end
		ent_rd_q <= ent_mem[ptr_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.ins_write) begin
			nxt_mem[new_idx] <= {1'b1, {IDX_W{1'b0}}};
		end else if (cmd.link_write) begin
			nxt_mem[link_addr_q] <= {1'b0, link_data_q};
		end
		nxt_rd_q <= nxt_mem[ptr_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.ptr_head) begin
			ptr_q <= head_q[bkt_q];
		end else if (cmd.ptr_next && !sts.hit) begin
			ptr_q <= nxt_rd_q[IDX_W-1:0];
		end
	end

	always_comb begin
		sts.key_bad   = bad_q;
		sts.is_lookup = (func_q == FUNC_LOOKUP);
		sts.full      = (cnt_q == CNT_W'(POOL_ENTRIES));
		sts.head_used = head_vld_q[bkt_q];
		sts.hit       = (ent_rd_q.len == len_q) && (ent_rd_q.key == key_q);
		sts.chain_end = nxt_rd_q[IDX_W];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			status_q <= cmd.code;
			if (cmd.code == ST_OK && func_q == FUNC_LOOKUP) begin
				opc_out_q <= ent_rd_q.opc;
				fmt_out_q <= ent_rd_q.fmt;
			end else begin
				opc_out_q <= '0;
				fmt_out_q <= '0;
			end
			bkt_out_q <= (cmd.code == ST_BADKEY) ? 6'd0 : 6'(bkt_q);
		end
	end

	assign status       = status_q;
	assign found_opcode = opc_out_q;
	assign found_format = fmt_out_q;
	assign bucket_index = bkt_out_q;

endmodule

// ===== sv/opcode_hash_table.sv =====
// Mnemonic-to-opcode table: a chained hash table over a fixed entry pool.
// Input channel (in_valid/in_ready): one beat carries func (0 insert,
// 1 lookup), key_chars/key_length, and opcode_value/format_value for inserts.
// Output channel (out_valid/out_ready): one beat per input beat, in order,
// with status, found_opcode, found_format and bucket_index.
// One item is worked on at a time. An insert runs hash, modulo, decide,
// insert and, if the bucket was in use, link; a lookup runs hash, modulo,
// decide, then per chain entry a registered entry pool read and a compare.
// A rejected key (bad character, full pool, empty bucket) ends at decide.
// The output register holds the finished beat; a new item is accepted while
// it waits, and the next result is held back until the receiver takes the
// previous one, so out_ready low stalls the block without loss.
// Reset clears the bucket valid bits and the entry count, so the table
// starts empty; entry storage is not cleared and no warm-up is needed.
module opcode_hash_table #(
	parameter int BUCKET_COUNT = ohtab_pkg::DEF_BUCKET_COUNT,
	parameter int POOL_ENTRIES = ohtab_pkg::DEF_POOL_ENTRIES,
	parameter int KEY_CHARS    = ohtab_pkg::DEF_KEY_CHARS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [63:0] key_chars,
	input  logic [3:0]  key_length,
	input  logic [7:0]  opcode_value,
	input  logic [3:0]  format_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [7:0]  found_opcode,
	output logic [3:0]  found_format,
	output logic [5:0]  bucket_index
);
	import ohtab_pkg::*;

	oht_cmd_t cmd;
	oht_sts_t sts;

	ohtab_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ohtab_dpath #(
		.BUCKET_COUNT (BUCKET_COUNT),
		.POOL_ENTRIES (POOL_ENTRIES),
		.KEY_CHARS    (KEY_CHARS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.func         (func),
		.key_chars    (key_chars),
		.key_length   (key_length),
		.opcode_value (opcode_value),
		.format_value (format_value),
		.status       (status),
		.found_opcode (found_opcode),
		.found_format (found_format),
		.bucket_index (bucket_index)
	);

endmodule

// ===== sim/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ohtab_pkg::*;

	localparam int BUCKET_N  = DEF_BUCKET_COUNT;
	localparam int POOL_N    = DEF_POOL_ENTRIES;
	localparam int KEY_N     = DEF_KEY_CHARS;
	localparam int LINK_NONE = 64;
	localparam int RAND_PER_PHASE = 217;
	localparam int STALL_LIMIT    = 3000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int DIR_N          = 23;

	typedef struct packed {
		status_code_t status;
		logic [7:0]   opcode;
		logic [3:0]   fmt;
		logic [5:0]   bucket;
	} reply_t;

	typedef struct packed {
		logic       fn;
		logic [63:0] key;
		logic [3:0] len;
		logic [7:0] opc;
		logic [3:0] fmt;
		logic       typed;
		reply_t     want;
	} row_t;

	typedef struct packed {
		logic [63:0] key;
		logic [3:0]  len;
	} stored_key_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        func = FUNC_INSERT;
	logic [63:0] key_chars = '0;
	logic [3:0]  key_length = '0;
	logic [7:0]  opcode_value = '0;
	logic [3:0]  format_value = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic [7:0]  found_opcode;
	logic [3:0]  found_format;
	logic [5:0]  bucket_index;

	opcode_hash_table u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.key_chars    (key_chars),
		.key_length   (key_length),
		.opcode_value (opcode_value),
		.format_value (format_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.found_opcode (found_opcode),
		.found_format (found_format),
		.bucket_index (bucket_index)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// table model state
	logic [6:0]  head_q [BUCKET_N];
	logic [5:0]  tail_q [BUCKET_N];
	logic [63:0] ent_key [POOL_N];
	logic [3:0]  ent_len [POOL_N];
	logic [7:0]  ent_opc [POOL_N];
	logic [3:0]  ent_fmt [POOL_N];
	logic [6:0]  ent_next [POOL_N];
	logic [6:0]  used_cnt;
	stored_key_t known_keys [$];

	reply_t replies_due [$];
	int     errors = 0;
	int     beats_seen = 0;
	int     status_tally [4] = '{0, 0, 0, 0};
	int     send_idle_pct = 0;
	int     recv_idle_pct = 0;
	int     idle_cycles = 0;

	row_t directed_rows [DIR_N] = '{
		'{FUNC_LOOKUP, 64'h0, 4'd0, 8'h00, 4'd0, 1'b1, '{ST_NOTFOUND, 8'h00, 4'd0, 6'd0}},
		'{FUNC_LOOKUP, 64'h5A, 4'd1, 8'h00, 4'd0, 1'b1, '{ST_NOTFOUND, 8'h00, 4'd0, 6'd5}},
		'{FUNC_INSERT, 64'h41, 4'd1, 8'hFF, 4'd9, 1'b1, '{ST_OK, 8'h00, 4'd0, 6'd0}},
		'{FUNC_LOOKUP, 64'h41, 4'd1, 8'h00, 4'd0, 1'b1, '{ST_OK, 8'hFF, 4'd9, 6'd0}},
		'{FUNC_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 8'h00, 4'd0, 1'b1,
			'{ST_OK, 8'h00, 4'd0, 6'd0}},
		'{FUNC_LOOKUP, 64'h1234_5678_9ABC_DEF0, 4'd0, 8'hC3, 4'd5, 1'b1,
			'{ST_OK, 8'h00, 4'd0, 6'd0}},
		'{FUNC_INSERT, 64'h5A5A_5A5A_5A5A_5A5A, 4'd8, 8'hA5, 4'hF, 1'b1,
			'{ST_OK, 8'h00, 4'd0, 6'd0}},
		'{FUNC_LOOKUP, 64'h5A5A_5A5A_5A5A_5A5A, 4'd15, 8'h00, 4'd0, 1'b1,
			'{ST_OK, 8'hA5, 4'hF, 6'd0}},
		'{FUNC_INSERT, 64'h61, 4'd1, 8'h12, 4'd1, 1'b1, '{ST_BADKEY, 8'h00, 4'd0, 6'd0}},
		'{FUNC_LOOKUP, 64'h40, 4'd1, 8'h00, 4'd0, 1'b1, '{ST_BADKEY, 8'h00, 4'd0, 6'd0}},
		'{FUNC_INSERT, 64'h5B, 4'd1, 8'h34, 4'd2, 1'b1, '{ST_BADKEY, 8'h00, 4'd0, 6'd0}},
		'{FUNC_LOOKUP, 64'h8047_4645_4443_4241, 4'd8, 8'h00, 4'd0, 1'b1,
			'{ST_BADKEY, 8'h00, 4'd0, 6'd0}},
		'{FUNC_LOOKUP, 64'h8047_4645_4443_4241, 4'd7, 8'h00, 4'd0, 1'b1,
			'{ST_NOTFOUND, 8'h00, 4'd0, 6'd1}},
		'{FUNC_INSERT, 64'hFFFF_FFFF_FFFF_4241, 4'd2, 8'h11, 4'd3, 1'b1,
			'{ST_OK, 8'h00, 4'd0, 6'd1}},
		'{FUNC_LOOKUP, 64'h0000_0000_0080_4241, 4'd2, 8'h00, 4'd0, 1'b0, '0},
		'{FUNC_INSERT, 64'h4241, 4'd2, 8'h22, 4'd7, 1'b0, '0},
		'{FUNC_LOOKUP, 64'h4241, 4'd2, 8'h00, 4'd0, 1'b0, '0},
		'{FUNC_LOOKUP, 64'h4142, 4'd2, 8'h00, 4'd0, 1'b0, '0},
		'{FUNC_LOOKUP, 64'h005A_5A5A_5A5A_5A5A, 4'd7, 8'h00, 4'd0, 1'b0, '0},
		'{FUNC_INSERT, 64'h41_444C, 4'd3, 8'h00, 4'd3, 1'b0, '0},
		'{FUNC_LOOKUP, 64'h41_444C, 4'd3, 8'h00, 4'd0, 1'b0, '0},
		'{FUNC_INSERT, 64'h5A, 4'd9, 8'h56, 4'd1, 1'b1, '{ST_BADKEY, 8'h00, 4'd0, 6'd0}},
		'{FUNC_LOOKUP, 64'h5A, 4'd1, 8'h00, 4'd0, 1'b1, '{ST_NOTFOUND, 8'h00, 4'd0, 6'd5}}
	};

	function automatic reply_t table_response(input logic fn, input logic [63:0] key_in,
			input logic [3:0] len_in, input logic [7:0] opc, input logic [3:0] fmt);
		reply_t      r;
		logic [3:0]  len;
		logic [63:0] k;
		logic [7:0]  c;
		logic        bad;
		int          sum;
		int          i;
		int          p;
		int          steps;
		int          bkt;
		int          e;
		r = '{ST_OK, 8'h00, 4'd0, 6'd0};
		len = (len_in > KEY_N) ? 4'(KEY_N) : len_in;
		k = key_in;
		sum = 0;
		bad = 1'b0;
		for (i = 0; i < 8; i++) begin
			c = k[8*i +: 8];
			if (i >= len)
				k[8*i +: 8] = 8'h00;
			else if (c < CHAR_FIRST || c > CHAR_LAST)
				bad = 1'b1;
			else
				sum += int'(c) - int'(CHAR_FIRST);
		end
		bkt = sum % BUCKET_N;
		if (bad) begin
			r.status = ST_BADKEY;
			return r;
		end
		r.bucket = 6'(bkt);
		if (fn == FUNC_INSERT) begin
			if (used_cnt >= POOL_N) begin
				r.status = ST_FULL;
			end else begin
				e = used_cnt;
				ent_key[e] = k;
				ent_len[e] = len;
				ent_opc[e] = opc;
				ent_fmt[e] = fmt;
				ent_next[e] = 7'(LINK_NONE);
				if (head_q[bkt] == LINK_NONE)
					head_q[bkt] = 7'(e);
				else
					ent_next[tail_q[bkt]] = 7'(e);
				tail_q[bkt] = 6'(e);
				used_cnt = used_cnt + 7'd1;
				known_keys.push_back('{k, len});
			end
		end else begin
			r.status = ST_NOTFOUND;
			p = head_q[bkt];
			steps = 0;
			while (p < POOL_N && steps < POOL_N && r.status == ST_NOTFOUND) begin
				if (ent_len[p] == len && ent_key[p] == k) begin
					r.status = ST_OK;
					r.opcode = ent_opc[p];
					r.fmt = ent_fmt[p];
				end else begin
					p = ent_next[p];
				end
				steps++;
			end
		end
		return r;
	endfunction

	// random uppercase chars in the low n bytes, random bytes above
	function automatic logic [63:0] mnemonic(input int n);
		logic [63:0] k;
		int          i;
		k = {$urandom, $urandom};
		for (i = 0; i < n; i++)
			k[8*i +: 8] = CHAR_FIRST + 8'($urandom_range(25));
		return k;
	endfunction

	task automatic flag(input string what, input int got, input int want);
		errors++;
		$display("MISMATCH beat %0d %s: got %0d want %0d", beats_seen, what, got, want);
	endtask

	task automatic send_beat(input row_t row);
		reply_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= row.fn;
		key_chars <= row.key;
		key_length <= row.len;
		opcode_value <= row.opc;
		format_value <= row.fmt;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		r = table_response(row.fn, row.key, row.len, row.opc, row.fmt);
		replies_due.push_back(row.typed ? row.want : r);
	endtask

	always @(posedge clk) begin
		reply_t want;
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
		if (arst_n && out_valid && out_ready) begin
			if (replies_due.size() == 0) begin
				flag("unexpected beat, status", int'(status), -1);
			end else begin
				want = replies_due.pop_front();
				if (status !== want.status)
					flag("status", int'(status), int'(want.status));
				if (found_opcode !== want.opcode)
					flag("found_opcode", int'(found_opcode), int'(want.opcode));
				if (found_format !== want.fmt)
					flag("found_format", int'(found_format), int'(want.fmt));
				if (bucket_index !== want.bucket)
					flag("bucket_index", int'(bucket_index), int'(want.bucket));
				status_tally[want.status]++;
			end
			beats_seen++;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout: no beat for %0d cycles, %0d results pending",
				STALL_LIMIT, replies_due.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		row_t        row;
		stored_key_t sk;
		int          ph;
		int          n;
		int          i;
		int          roll;
		for (i = 0; i < BUCKET_N; i++) begin
			head_q[i] = 7'(LINK_NONE);
			tail_q[i] = '0;
		end
		used_cnt = '0;
		send_idle_pct = 26;
		recv_idle_pct = 80;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < DIR_N; i++)
			send_beat(directed_rows[i]);

		for (ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 26 : (ph == 1) ? 80 : 0;
			recv_idle_pct = (ph == 0) ? 80 : (ph == 1) ? 26 : 0;
			for (n = 0; n < RAND_PER_PHASE; n++) begin
				row = '0;
				roll = $urandom_range(99);
				row.fn = FUNC_LOOKUP;
				row.len = 4'($urandom_range(KEY_N));
				row.key = mnemonic(row.len);
				row.opc = 8'($urandom);
				row.fmt = 4'($urandom_range(15));
				if (roll < 18)
					row.fn = FUNC_INSERT;
				if ((roll < 4 || (roll >= 18 && roll < 70)) && known_keys.size() != 0) begin
					sk = known_keys[$urandom_range(known_keys.size() - 1)];
					row.len = sk.len;
					row.key = {$urandom, $urandom};
					for (i = 0; i < sk.len; i++)
						row.key[8*i +: 8] = sk.key[8*i +: 8];
				end else if (roll >= 88) begin
					row.fn = 1'($urandom_range(1));
					row.key = {$urandom, $urandom};
					row.len = 4'($urandom_range(15));
				end
				if (row.len == KEY_N && $urandom_range(3) == 0)
					row.len = 4'($urandom_range(15, KEY_N + 1));
				send_beat(row);
			end
		end
		in_valid <= 1'b0;

		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d beats checked, %0d pool entries used, %0d mismatches", beats_seen,
			used_cnt, errors);
		$display("results: %0d ok, %0d bad key, %0d not found, %0d pool full",
			status_tally[ST_OK], status_tally[ST_BADKEY], status_tally[ST_NOTFOUND],
			status_tally[ST_FULL]);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
